### hdl/qdu_pkg.sv
// ----------------------------------------------------------------------------
// qdu_pkg
// Shared types and constants of the quantize/dequantize unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qdu_pkg;

    localparam int SIG_W  = 24;
    localparam int PROD_W = 2 * SIG_W;
    localparam int EXP_W  = 10;

    typedef enum logic {
        OP_QUANT   = 1'b0,
        OP_DEQUANT = 1'b1
    } t_opcode;

    typedef enum logic {
        MODE_SYM  = 1'b0,
        MODE_ASYM = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_RECIP  = 2'd2,
        CFG_OFFSET = 2'd3
    } t_cfg_index;

    localparam logic [31:0] FP_ONE         = 32'h3F80_0000;
    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET       = 32'h0040_0000;
    localparam logic [30:0] FP_INF_MAG     = 31'h7F80_0000;

    localparam logic [7:0] SYM_MAX  = 8'h7F;
    localparam logic [7:0] SYM_MIN  = 8'h80;
    localparam logic [7:0] ASYM_MAX = 8'hFF;
    localparam logic [7:0] ASYM_MIN = 8'h00;

    // unnormalized product: value = sig * 2^expo
    typedef struct packed {
        logic                    sign;
        logic [PROD_W-1:0]       sig;
        logic signed [EXP_W-1:0] expo;
    } t_prod;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] offset;
    } t_qcfg;

endpackage

### hdl/qdu_in_if.sv
// ----------------------------------------------------------------------------
// qdu_in_if
// Element input channel: valid/ready with opcode, data and last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qdu_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] data_in;
    logic        last_in;

    modport source (output valid, opcode, data_in, last_in, input ready);
    modport sink   (input valid, opcode, data_in, last_in, output ready);
endinterface

### hdl/qdu_out_if.sv
// ----------------------------------------------------------------------------
// qdu_out_if
// Result channel: valid/ready with data, scale error and last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qdu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_out;
    logic        scale_error;
    logic        last_out;

    modport source (output valid, data_out, scale_error, last_out, input ready);
    modport sink   (input valid, data_out, scale_error, last_out, output ready);
endinterface

### hdl/quantize_dequantize_unit.sv
// ----------------------------------------------------------------------------
// quantize_dequantize_unit
// Affine int8/uint8 quantize and dequantize of fp32 elements.
// Pipeline: the input transfer loads the unpacked operands, then 24x24
// multiply, normalize/round, and code conversion into the output register.
// Throughput: one element per cycle; the whole pipeline holds on output stall.
// Reset: synchronous active low; clears pipeline valids, loads scale and
// inverse scale with 1.0, symmetric, offset 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quantize_dequantize_unit import qdu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    qdu_in_if.sink      i_in,
    qdu_out_if.source   o_out
);

    function automatic logic signed [EXP_W-1:0] fp_exp(input logic [7:0] ef);
        logic [7:0] eff;
        eff = (ef == 8'd0) ? 8'd1 : ef;
        return $signed({2'b0, eff}) - 10'sd150;
    endfunction

    // configuration
    t_mode       r_mode;
    logic [31:0] r_scale;
    logic [31:0] r_recip;
    logic [7:0]  r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SYM;
            r_scale  <= FP_ONE;
            r_recip  <= FP_ONE;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MODE:   r_mode   <= t_mode'(i_cfg_data[0]);
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_RECIP:  r_recip  <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic r_out_valid;
    logic en;
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // unpack operands
    t_opcode            in_op;
    logic [31:0]        b_bits;
    logic               a_sign, a_nan, a_inf, a_zero;
    logic               b_nan, b_inf, b_zero;
    logic [SIG_W-1:0]   a_sig, b_sig;
    logic signed [EXP_W-1:0] a_exp;
    logic signed [8:0]  dq;
    logic [8:0]         dq_mag;
    logic               p_sign;
    logic               sc_nan;
    logic               n1_err;
    logic               n1_spec;
    logic [31:0]        n1_spec_bits;

    always_comb begin
        in_op  = t_opcode'(i_in.opcode);
        b_bits = (in_op == OP_QUANT) ? r_recip : r_scale;
        dq     = '0;
        dq_mag = '0;
        if (in_op == OP_QUANT) begin
            a_sign = i_in.data_in[31];
            a_nan  = (i_in.data_in[30:23] == 8'hFF) && (i_in.data_in[22:0] != 23'd0);
            a_inf  = (i_in.data_in[30:23] == 8'hFF) && (i_in.data_in[22:0] == 23'd0);
            a_zero = i_in.data_in[30:0] == 31'd0;
            a_sig  = {i_in.data_in[30:23] != 8'd0, i_in.data_in[22:0]};
            a_exp  = fp_exp(i_in.data_in[30:23]);
        end else begin
            if (r_mode == MODE_SYM) begin
                dq = $signed({i_in.data_in[7], i_in.data_in[7:0]});
            end else begin
                dq = $signed({1'b0, i_in.data_in[7:0]} - {1'b0, r_offset});
            end
            dq_mag = dq[8] ? 9'(-dq) : 9'(dq);
            a_sign = dq[8];
            a_nan  = 1'b0;
            a_inf  = 1'b0;
            a_zero = dq == 9'sd0;
            a_sig  = SIG_W'(dq_mag);
            a_exp  = '0;
        end

        b_nan  = (b_bits[30:23] == 8'hFF) && (b_bits[22:0] != 23'd0);
        b_inf  = (b_bits[30:23] == 8'hFF) && (b_bits[22:0] == 23'd0);
        b_zero = b_bits[30:0] == 31'd0;
        b_sig  = {b_bits[30:23] != 8'd0, b_bits[22:0]};
        p_sign = a_sign ^ b_bits[31];

        n1_spec      = 1'b1;
        n1_spec_bits = '0;
        if (a_nan) begin
            n1_spec_bits = i_in.data_in | FP_QUIET;
        end else if (b_nan) begin
            n1_spec_bits = b_bits | FP_QUIET;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            n1_spec_bits = FP_DEFAULT_NAN;
        end else if (a_inf || b_inf) begin
            n1_spec_bits = {p_sign, FP_INF_MAG};
        end else if (a_zero || b_zero) begin
            n1_spec_bits = {p_sign, 31'd0};
        end else begin
            n1_spec = 1'b0;
        end

        // scale <= 0 covers both zeros and every negative non-NaN pattern
        sc_nan = (r_scale[30:23] == 8'hFF) && (r_scale[22:0] != 23'd0);
        n1_err = (in_op == OP_QUANT) && !sc_nan
                 && (r_scale[31] || r_scale[30:0] == 31'd0);
    end

    // stage 1: unpacked operands
    logic                    r1_valid;
    t_opcode                 r1_op;
    logic                    r1_last;
    logic                    r1_err;
    logic                    r1_spec;
    logic [31:0]             r1_spec_bits;
    logic                    r1_sign;
    logic [SIG_W-1:0]        r1_sig_a;
    logic [SIG_W-1:0]        r1_sig_b;
    logic signed [EXP_W-1:0] r1_expo;

    // stage 2: raw product
    logic        r2_valid;
    t_opcode     r2_op;
    logic        r2_last;
    logic        r2_err;
    logic        r2_spec;
    logic [31:0] r2_spec_bits;
    t_prod       r2_prod;

    // stage 3: fp32 product
    logic        r3_valid;
    t_opcode     r3_op;
    logic        r3_last;
    logic        r3_err;
    logic [31:0] r3_bits;

    logic [31:0] r_data_out;
    logic        r_scale_error;
    logic        r_last_out;

    logic [31:0] rnd_bits;
    logic [7:0]  q_code;
    logic [31:0] n_data_out;
    t_qcfg       qcfg;

    assign qcfg = '{mode: r_mode, offset: r_offset};

    qdu_round u_round (
        .i_prod (r2_prod),
        .o_bits (rnd_bits)
    );

    qdu_code u_code (
        .i_cfg  (qcfg),
        .i_bits (r3_bits),
        .o_code (q_code)
    );

    always_comb begin
        if (r3_err) begin
            n_data_out = '0;
        end else if (r3_op == OP_QUANT) begin
            n_data_out = {24'd0, q_code};
        end else begin
            n_data_out = r3_bits;
        end
    end

    // control: advance every stage together, hold on output stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_in.valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op        <= in_op;
            r1_last      <= i_in.last_in;
            r1_err       <= n1_err;
            r1_spec      <= n1_spec;
            r1_spec_bits <= n1_spec_bits;
            r1_sign      <= p_sign;
            r1_sig_a     <= a_sig;
            r1_sig_b     <= b_sig;
            r1_expo      <= a_exp + fp_exp(b_bits[30:23]);

            r2_op        <= r1_op;
            r2_last      <= r1_last;
            r2_err       <= r1_err;
            r2_spec      <= r1_spec;
            r2_spec_bits <= r1_spec_bits;
            r2_prod.sign <= r1_sign;
            r2_prod.sig  <= r1_sig_a * r1_sig_b;
            r2_prod.expo <= r1_expo;

            r3_op        <= r2_op;
            r3_last      <= r2_last;
            r3_err       <= r2_err;
            r3_bits      <= r2_spec ? r2_spec_bits : rnd_bits;

            r_data_out    <= n_data_out;
            r_scale_error <= r3_err;
            r_last_out    <= r3_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.data_out    = r_data_out;
    assign o_out.scale_error = r_scale_error;
    assign o_out.last_out    = r_last_out;

endmodule

### hdl/qdu_round.sv
// ----------------------------------------------------------------------------
// qdu_round
// Normalizes a raw significand product and rounds it to fp32, nearest even,
// with subnormal results and overflow to infinity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdu_round import qdu_pkg::*; (
    input  t_prod       i_prod,
    output logic [31:0] o_bits
);

    logic [5:0]        msb;
    logic [5:0]        lsh;
    logic [PROD_W-1:0] norm;
    logic signed [10:0] biased;
    logic [8:0]        be_m1;
    logic [7:0]        rsh;
    logic [PROD_W-1:0] lost_mask;
    logic [PROD_W-1:0] shifted;
    logic              lost;
    logic [23:0]       mant;
    logic              guard;
    logic              sticky;
    logic              inc;
    logic [24:0]       rnd;
    logic [32:0]       big;

    always_comb begin
        msb = '0;
        for (int i = 0; i < PROD_W; i++) begin
            if (i_prod.sig[i]) begin
                msb = 6'(i);
            end
        end
        lsh    = 6'(PROD_W - 1) - msb;
        norm   = i_prod.sig << lsh;
        biased = $signed({5'b0, msb}) + 11'(i_prod.expo) + 11'sd127;

        // below the normal range, shift further right into the subnormal grid
        if (biased >= 11'sd1) begin
            be_m1 = 9'(biased - 11'sd1);
            rsh   = '0;
        end else begin
            be_m1 = '0;
            rsh   = 8'(11'sd1 - biased);
        end

        lost_mask = '0;
        if (rsh >= 8'(PROD_W)) begin
            shifted = '0;
            lost    = |norm;
        end else begin
            lost_mask = (PROD_W'(1) << rsh) - PROD_W'(1);
            shifted   = norm >> rsh;
            lost      = |(norm & lost_mask);
        end

        mant   = shifted[PROD_W-1 -: 24];
        guard  = shifted[PROD_W-25];
        sticky = (|shifted[PROD_W-26:0]) | lost;
        inc    = guard & (sticky | mant[0]);
        rnd    = {1'b0, mant} + 25'(inc);

        // hidden bit carries into the exponent field on its own
        big = 33'({be_m1, 23'b0}) + 33'(rnd);
        if (big >= 33'(FP_INF_MAG)) begin
            o_bits = {i_prod.sign, FP_INF_MAG};
        end else begin
            o_bits = {i_prod.sign, big[30:0]};
        end
    end

endmodule

### hdl/qdu_code.sv
// ----------------------------------------------------------------------------
// qdu_code
// Turns an fp32 product into an 8-bit code: optional zero point add with
// fp32 rounding, round half away from zero, saturation, NaN to low bound.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qdu_code import qdu_pkg::*; (
    input  t_qcfg       i_cfg,
    input  logic [31:0] i_bits,
    output logic [7:0]  o_code
);

    logic [7:0]         ef;
    logic [7:0]         ef_eff;
    logic [23:0]        mant;
    logic               sign;
    logic               is_nan;
    logic               is_big;
    logic [3:0]         ls;
    logic [6:0]         rs;
    logic [23:0]        st_mask;
    logic [35:0]        qt;
    logic               q_st;
    logic [36:0]        mag_sum;
    logic [9:0]         mag;
    logic [7:0]         code_sym;
    logic signed [37:0] zp_fix;
    logic signed [37:0] s_fix;
    logic signed [37:0] x_fix;
    logic [9:0]         ipart;
    logic [3:0]         imsb;
    logic [37:0]        bias;
    logic [10:0]        cv;
    logic [7:0]         code_asym;

    always_comb begin
        ef      = i_bits[30:23];
        ef_eff  = (ef == 8'd0) ? 8'd1 : ef;
        mant    = {ef != 8'd0, i_bits[22:0]};
        sign    = i_bits[31];
        is_nan  = (ef == 8'hFF) && (i_bits[22:0] != 23'd0);
        is_big  = ef >= 8'd136;

        // magnitude as fixed point with 27 fraction bits plus sticky
        ls      = '0;
        rs      = '0;
        st_mask = '0;
        qt      = '0;
        q_st    = 1'b0;
        if (!is_big) begin
            if (ef >= 8'd123) begin
                ls = 4'(ef - 8'd123);
                qt = 36'(mant) << ls;
            end else begin
                rs = 7'(8'd123 - ef_eff);
                if (rs >= 7'd24) begin
                    q_st = |mant;
                end else begin
                    st_mask = (24'd1 << rs) - 24'd1;
                    qt      = 36'(mant >> rs);
                    q_st    = |(mant & st_mask);
                end
            end
        end

        // symmetric: product rounded directly
        mag_sum = 37'(qt) + (37'd1 << 26);
        mag     = mag_sum[36:27];
        if (is_nan) begin
            code_sym = SYM_MIN;
        end else if (sign) begin
            code_sym = (is_big || mag >= 10'd128) ? SYM_MIN : 8'(10'd0 - mag);
        end else begin
            code_sym = (is_big || mag >= 10'd127) ? SYM_MAX : mag[7:0];
        end

        // asymmetric: exact sum, biased by half an ulp of its binade so the
        // fp32 rounding of the sum is folded into the code threshold
        zp_fix = $signed({3'b0, i_cfg.offset, 27'b0});
        if (sign) begin
            s_fix = zp_fix - $signed({2'b0, qt}) - 38'(q_st);
        end else begin
            s_fix = zp_fix + $signed({2'b0, qt});
        end
        ipart = s_fix[36:27];
        imsb  = '0;
        for (int i = 0; i < 10; i++) begin
            if (ipart[i]) begin
                imsb = 4'(i);
            end
        end
        bias  = (ipart == 10'd0) ? 38'd2 : (38'd1 << (imsb + 4'd3));
        x_fix = s_fix + $signed(38'd1 << 26) + $signed(bias);
        cv    = x_fix[37:27];
        if (is_nan || (is_big && sign) || s_fix < 0) begin
            code_asym = ASYM_MIN;
        end else if (is_big || cv >= 11'd255) begin
            code_asym = ASYM_MAX;
        end else begin
            code_asym = cv[7:0];
        end

        o_code = (i_cfg.mode == MODE_ASYM) ? code_asym : code_sym;
    end

endmodule

### tb/sv/quantize_dequantize_unit_tb.sv
// ----------------------------------------------------------------------------
// quantize_dequantize_unit_tb
// Streams fp32 values and 8-bit codes through the unit under a series of
// register settings and random handshake gaps. Each transfer is checked
// against a bit-exact fp32 predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quantize_dequantize_unit_tb;
    import qdu_pkg::*;

    typedef struct {
        logic [31:0] data;
        logic        err;
        logic        last;
    } t_qdu_result;

    class qdu_scoreboard;
        t_mode       mode = MODE_SYM;
        logic [31:0] scale = FP_ONE;
        logic [31:0] recip = FP_ONE;
        logic [7:0]  offset = 8'h00;
        t_qdu_result pending[$];
        int          mismatches = 0;

        static function bit is_nan(logic [31:0] b);
            return b[30:23] == 8'hFF && b[22:0] != 0;
        endfunction

        static function bit is_inf(logic [31:0] b);
            return b[30:0] == FP_INF_MAG;
        endfunction

        static function real fp32_to_real(logic [31:0] b);
            logic [63:0] d;
            logic [23:0] mm;
            int          e;
            e = b[30:23];
            mm = {1'b0, b[22:0]};
            if (e == 255) begin
                d = {b[31], 11'h7FF, (mm != 0) ? 52'h8_0000_0000_0000 : 52'h0};
            end else if (e == 0) begin
                if (mm == 0) begin
                    d = {b[31], 63'h0};
                end else begin
                    // normalize the subnormal into double format
                    e = -126;
                    while (!mm[23]) begin
                        mm = mm << 1;
                        e--;
                    end
                    e = e - 1;
                    mm = mm << 0;
                    d = {b[31], 11'(e + 1023 + 1), mm[22:0], 29'h0};
                end
            end else begin
                d = {b[31], 11'(e - 127 + 1023), b[22:0], 29'h0};
            end
            return $bitstoreal(d);
        endfunction

        // round an exact double to fp32, nearest even, subnormals kept
        static function logic [31:0] real_to_fp32(real r);
            logic [63:0] d;
            logic [63:0] m;
            logic [63:0] q;
            logic [63:0] rem;
            logic [63:0] half;
            logic [63:0] mag;
            int          e;
            int          sh;
            d = $realtobits(r);
            if (d[62:52] == 11'h7FF)
                return {d[63], (d[51:0] != 0) ? 31'h7FC0_0000 : FP_INF_MAG};
            if (d[62:52] == 0)
                return {d[63], 31'h0};
            e = int'(d[62:52]) - 1023;
            if (e >= 128)
                return {d[63], FP_INF_MAG};
            sh = (e >= -126) ? 29 : 29 + (-126 - e);
            if (sh >= 60)
                return {d[63], 31'h0};
            m = {11'h0, 1'b1, d[51:0]};
            q = m >> sh;
            rem = m & ((64'h1 << sh) - 1);
            half = 64'h1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 1;
            if (e >= -126)
                mag = (64'(e + 127) << 23) + q - (64'h1 << 23);
            else
                mag = q;
            if (mag >= 64'h7F80_0000)
                mag = 64'h7F80_0000;
            return {d[63], mag[30:0]};
        endfunction

        // half away from zero, then clamp; NaN goes to the low bound
        static function int round_clamp(logic [31:0] vb, int lo, int hi);
            real v;
            real frac;
            int  t;
            if (is_nan(vb))
                return lo;
            v = fp32_to_real(vb);
            if (v >= hi)
                return hi;
            if (v <= lo)
                return lo;
            t = $rtoi(v);
            frac = v - t;
            if (frac >= 0.5)
                t++;
            else if (frac <= -0.5)
                t--;
            if (t > hi)
                t = hi;
            if (t < lo)
                t = lo;
            return t;
        endfunction

        function t_qdu_result quantize_element(t_opcode op, logic [31:0] x, logic last);
            t_qdu_result res;
            logic [31:0] prod;
            logic [31:0] sum;
            int          code;
            int          k;
            res.data = 32'h0;
            res.err = 1'b0;
            res.last = last;
            if (op == OP_QUANT) begin
                if (!is_nan(scale) && (scale[31] || scale[30:0] == 0)) begin
                    res.err = 1'b1;
                end else begin
                    if (is_nan(x) || is_nan(recip)
                            || (is_inf(x) && recip[30:0] == 0)
                            || (x[30:0] == 0 && is_inf(recip)))
                        prod = FP_DEFAULT_NAN;
                    else
                        prod = real_to_fp32(fp32_to_real(x) * fp32_to_real(recip));
                    if (mode == MODE_SYM) begin
                        code = round_clamp(prod, -128, 127);
                    end else begin
                        if (is_nan(prod))
                            sum = FP_DEFAULT_NAN;
                        else
                            sum = real_to_fp32(fp32_to_real(prod) + real'(offset));
                        code = round_clamp(sum, 0, 255);
                    end
                    res.data = {24'h0, 8'(code)};
                end
            end else begin
                if (mode == MODE_SYM)
                    k = int'($signed(x[7:0]));
                else
                    k = int'(x[7:0]) - int'(offset);
                if (is_nan(scale))
                    res.data = scale | FP_QUIET;
                else if (k == 0 && is_inf(scale))
                    res.data = FP_DEFAULT_NAN;
                else
                    res.data = real_to_fp32(real'(k) * fp32_to_real(scale));
            end
            return res;
        endfunction

        function void note_input(t_opcode op, logic [31:0] x, logic last);
            pending.push_back(quantize_element(op, x, last));
        endfunction

        function void check_result(logic [31:0] data, logic err, logic last);
            t_qdu_result exp_res;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result data=%h err=%b last=%b", data, err, last);
                return;
            end
            exp_res = pending.pop_front();
            if (data !== exp_res.data || err !== exp_res.err || last !== exp_res.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected data=%h err=%b last=%b, got data=%h err=%b last=%b",
                             exp_res.data, exp_res.err, exp_res.last, data, err, last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = 2'd0;
    logic [31:0] i_cfg_data = 32'h0;
    bit no_idle = 1'b0;
    int out_stall = 0;
    int cycles = 0;

    qdu_in_if  in_ch();
    qdu_out_if out_ch();
    qdu_scoreboard sb = new();

    quantize_dequantize_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[quantize_dequantize_unit] ERROR");
            $finish;
        end
    end

    // result side: random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (no_idle) begin
            out_ch.ready <= 1'b1;
        end else if (out_stall > 0) begin
            out_ch.ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25)
                out_stall <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_input(t_opcode'(in_ch.opcode), in_ch.data_in, in_ch.last_in);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.data_out, out_ch.scale_error, out_ch.last_out);
        end
    end

    task automatic send_element(t_opcode op, logic [31:0] x, logic last);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.data_in <= x;
        in_ch.last_in <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:   sb.mode = t_mode'(value[0]);
            CFG_SCALE:  sb.scale = value;
            CFG_RECIP:  sb.recip = value;
            CFG_OFFSET: sb.offset = value[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [31:0] m, logic [31:0] s, logic [31:0] inv,
                                 logic [31:0] zp);
        write_reg(CFG_MODE, m);
        write_reg(CFG_SCALE, s);
        write_reg(CFG_RECIP, inv);
        write_reg(CFG_OFFSET, zp);
    endtask

    function automatic logic [31:0] random_fp32();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: return $urandom;
            4, 5, 6: return {1'($urandom), 8'($urandom_range(115, 136)), 23'($urandom)};
            7: return qdu_scoreboard::real_to_fp32(
                   real'($urandom_range(0, 600)) - 300.0 + 0.5);
            8: begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7F80_0000;
                    3: return 32'hFF80_0000;
                    4: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
                    default: return 32'h7F7F_FFFF;
                endcase
            end
            default: return {1'($urandom), 8'h00, 23'($urandom)};
        endcase
    endfunction

    initial begin
        logic [31:0] directed_vals[18];
        logic [31:0] x;
        t_opcode     op;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_QUANT;
        in_ch.data_in = 32'h0;
        in_ch.last_in = 1'b0;
        directed_vals = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'hBF00_0000,
                          32'h3FC0_0000, 32'h4020_0000, 32'hC020_0000, 32'h42FF_0000,
                          32'hC301_0000, 32'h4348_0000, 32'hC348_0000, 32'h7F80_0000,
                          32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001, 32'h7F7F_FFFF,
                          32'hFFFF_FFFF, 32'h3EFF_FFFF};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults straight out of reset: half-way cases, saturation, specials
        foreach (directed_vals[i])
            send_element(OP_QUANT, directed_vals[i], i == 17);
        send_element(OP_DEQUANT, 32'hFFFF_FF00, 1'b0);
        send_element(OP_DEQUANT, 32'h0000_007F, 1'b0);
        send_element(OP_DEQUANT, 32'hA5A5_A580, 1'b0);
        send_element(OP_DEQUANT, 32'h5A5A_5AFF, 1'b1);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0:  load_settings(MODE_SYM, FP_ONE, FP_ONE, 0);
                1:  load_settings(MODE_ASYM, 32'h3F00_0000, 32'h4000_0000, 128);
                2:  load_settings(MODE_ASYM, 32'h3C23_D70A, 32'h42C8_0000, 255);
                3:  load_settings(MODE_SYM, 32'h0000_0000, FP_ONE, 0);
                4:  load_settings(MODE_ASYM, 32'h8000_0000, FP_ONE, 7);
                5:  load_settings(MODE_SYM, 32'hBF80_0000, 32'h4000_0000, 0);
                6:  load_settings(MODE_SYM, 32'h7FC0_0000, 32'h7F80_0000, 0);
                7:  load_settings(MODE_ASYM, 32'h0000_0001, 32'h7F7F_FFFF, 0);
                8:  load_settings(MODE_SYM, 32'h7F7F_FFFF, 32'h0000_0001, 0);
                default: load_settings($urandom, $urandom, $urandom, $urandom);
            endcase
            no_idle = (phase == 2);
            for (int n = 0; n < 45; n++) begin
                op = t_opcode'($urandom_range(0, 2) == 0);
                x = (op == OP_QUANT) ? random_fp32() : $urandom;
                send_element(op, x, 1'($urandom_range(0, 7) == 0));
                // hold off until the pipeline has emptied
                if (phase == 4 && n == 20)
                    drain();
            end
            no_idle = 1'b0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[quantize_dequantize_unit] OK");
        end else begin
            $display("[quantize_dequantize_unit] ERROR");
        end
        $finish;
    end
endmodule
